// ===== rtl/core/binary_min_heap_priority_queue_top_assert.svh =====
// assertion macros for the binary min-heap priority queue
// used by the sequencer in rtl/core; no dependencies
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define BMHPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define BMHPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bmhpq_pkg.sv =====
// shared types, codes and constants of the binary min-heap priority queue
// no dependencies
package bmhpq_pkg;

	localparam int unsigned CAPACITY_DEF = 128;
	localparam int unsigned KEY_W        = 16;
	localparam int unsigned TAG_W        = 16;
	localparam int unsigned STATUS_W     = 2;
	localparam int unsigned OCC_W        = 8;
	localparam int unsigned ENTRY_W      = KEY_W + TAG_W;

	// operation codes
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0] prio;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic             mode;
		logic [KEY_W-1:0] new_priority;
		logic [TAG_W-1:0] new_tag;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    out_priority;
		logic [TAG_W-1:0]    out_tag;
		logic [OCC_W-1:0]    occupancy;
	} res_t;

endpackage

// ===== rtl/core/bmhpq_if.sv =====
// valid/ready channel interfaces for request and result beats
// depends on bmhpq_pkg
interface bmhpq_req_if;
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic [bmhpq_pkg::KEY_W-1:0]  new_priority;
	logic [bmhpq_pkg::TAG_W-1:0]  new_tag;

	modport source(output valid, mode, new_priority, new_tag, input ready);
	modport sink(input valid, mode, new_priority, new_tag, output ready);
endinterface

interface bmhpq_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [bmhpq_pkg::STATUS_W-1:0]  status;
	logic [bmhpq_pkg::KEY_W-1:0]     out_priority;
	logic [bmhpq_pkg::TAG_W-1:0]     out_tag;
	logic [bmhpq_pkg::OCC_W-1:0]     occupancy;

	modport source(output valid, status, out_priority, out_tag, occupancy, input ready);
	modport sink(input valid, status, out_priority, out_tag, occupancy, output ready);
endinterface

// ===== rtl/core/bmhpq_ram.sv =====
// generic ram: one write port, two read ports with registered read data
// depends on bmhpq_pkg for default sizes
module bmhpq_ram #(
	parameter int unsigned WIDTH = bmhpq_pkg::ENTRY_W,
	parameter int unsigned DEPTH = bmhpq_pkg::CAPACITY_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/core/bmhpq_ctrl.sv =====
// heap sequencer: sift-up / sift-down walk around one shared key comparator
// depends on bmhpq_pkg and the assertion macro header
`include "binary_min_heap_priority_queue_top_assert.svh"

module bmhpq_ctrl #(
	parameter int unsigned CAPACITY = bmhpq_pkg::CAPACITY_DEF,
	localparam int unsigned AW = $clog2(CAPACITY),
	localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  bmhpq_pkg::req_t               in_req,
	output logic                          res_valid,
	input  logic                          res_ready,
	output bmhpq_pkg::res_t               res,
	output logic                          ram_we,
	output logic [AW-1:0]                 ram_waddr,
	output logic [bmhpq_pkg::ENTRY_W-1:0] ram_wdata,
	output logic [AW-1:0]                 ram_raddr_a,
	output logic [AW-1:0]                 ram_raddr_b,
	input  logic [bmhpq_pkg::ENTRY_W-1:0] ram_rdata_a,
	input  logic [bmhpq_pkg::ENTRY_W-1:0] ram_rdata_b
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_UP_RD  = 3'd1;
	localparam logic [2:0] S_UP_CMP = 3'd2;
	localparam logic [2:0] S_RM_CAP = 3'd3;
	localparam logic [2:0] S_DN_RD  = 3'd4;
	localparam logic [2:0] S_DN_SEL = 3'd5;
	localparam logic [2:0] S_DN_CMP = 3'd6;
	localparam logic [2:0] S_FIN    = 3'd7;

	logic [2:0]                      state_q;
	logic [CW-1:0]                   count_q;
	logic [AW-1:0]                   pos_q;
	bmhpq_pkg::entry_t               cur_q;
	bmhpq_pkg::entry_t               pick_q;
	logic [AW-1:0]                   pick_addr_q;
	logic                            has_right_q;
	logic [bmhpq_pkg::STATUS_W-1:0]  status_q;
	logic [bmhpq_pkg::KEY_W-1:0]     out_prio_q;
	logic [bmhpq_pkg::TAG_W-1:0]     out_tag_q;

	bmhpq_pkg::entry_t               rd_a;
	bmhpq_pkg::entry_t               rd_b;
	logic                            accept;
	logic [AW-1:0]                   parent;
	logic [AW+1:0]                   left_w;
	logic [AW+1:0]                   right_w;
	logic [AW+1:0]                   cnt_w;
	logic                            no_child;
	logic                            right_ok;
	logic [bmhpq_pkg::KEY_W-1:0]     cmp_x;
	logic [bmhpq_pkg::KEY_W-1:0]     cmp_y;
	logic                            cmp_gt;

	assign rd_a      = bmhpq_pkg::entry_t'(ram_rdata_a);
	assign rd_b      = bmhpq_pkg::entry_t'(ram_rdata_b);
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == S_FIN);

	assign res.status       = status_q;
	assign res.out_priority = out_prio_q;
	assign res.out_tag      = out_tag_q;
	assign res.occupancy    = bmhpq_pkg::OCC_W'(count_q);

	// tree index arithmetic
	assign parent   = (pos_q - 1'b1) >> 1;
	assign left_w   = (AW + 2)'({pos_q, 1'b1});
	assign right_w  = left_w + 1'b1;
	assign cnt_w    = (AW + 2)'(count_q);
	assign no_child = (left_w >= cnt_w);
	assign right_ok = (right_w < cnt_w);

	// the one key comparator, operands steered by state
	always_comb begin
		case (state_q)
			S_UP_CMP: begin
				cmp_x = rd_a.prio;
				cmp_y = cur_q.prio;
			end
			S_DN_SEL: begin
				cmp_x = rd_a.prio;
				cmp_y = rd_b.prio;
			end
			default: begin
				cmp_x = cur_q.prio;
				cmp_y = pick_q.prio;
			end
		endcase
	end
	assign cmp_gt = (cmp_x > cmp_y);

	// ram port steering
	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = pos_q;
		ram_wdata   = cur_q;
		ram_raddr_a = '0;
		ram_raddr_b = '0;
		case (state_q)
			S_IDLE: begin
				if (count_q != '0) begin
					ram_raddr_b = AW'(count_q - 1'b1);
				end
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr_a = parent;
				end
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (cmp_gt) begin
					ram_wdata = rd_a;
				end
			end
			S_DN_RD: begin
				if (no_child) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr_a = AW'(left_w);
					ram_raddr_b = right_ok ? AW'(right_w) : AW'(left_w);
				end
			end
			S_DN_CMP: begin
				ram_we = 1'b1;
				if (cmp_gt) begin
					ram_wdata = pick_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						out_prio_q <= '0;
						out_tag_q  <= '0;
						status_q   <= bmhpq_pkg::ST_DONE;
						if (in_req.mode == bmhpq_pkg::MODE_INSERT) begin
							if (count_q == CW'(CAPACITY)) begin
								status_q <= bmhpq_pkg::ST_FULL;
								state_q  <= S_FIN;
							end else begin
								cur_q.prio <= in_req.new_priority;
								cur_q.tag  <= in_req.new_tag;
								pos_q      <= AW'(count_q);
								count_q    <= count_q + 1'b1;
								state_q    <= S_UP_RD;
							end
						end else begin
							if (count_q == '0) begin
								status_q <= bmhpq_pkg::ST_EMPTY;
								state_q  <= S_FIN;
							end else begin
								count_q <= count_q - 1'b1;
								state_q <= S_RM_CAP;
							end
						end
					end
				end
				S_UP_RD: begin
					state_q <= (pos_q == '0) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (cmp_gt) begin
						pos_q   <= parent;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_RM_CAP: begin
					out_prio_q <= rd_a.prio;
					out_tag_q  <= rd_a.tag;
					cur_q      <= rd_b;
					pos_q      <= '0;
					state_q    <= S_DN_RD;
				end
				S_DN_RD: begin
					if (no_child) begin
						state_q <= S_FIN;
					end else begin
						has_right_q <= right_ok;
						state_q     <= S_DN_SEL;
					end
				end
				S_DN_SEL: begin
					// right child wins only when strictly smaller
					if (has_right_q && cmp_gt) begin
						pick_q      <= rd_b;
						pick_addr_q <= AW'(right_w);
					end else begin
						pick_q      <= rd_a;
						pick_addr_q <= AW'(left_w);
					end
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (cmp_gt) begin
						pos_q   <= pick_addr_q;
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BMHPQ_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY),
		"entry count above capacity")
	`BMHPQ_ASSERT_SAME(a_no_write_idle, clk, arst_n, state_q == S_IDLE || state_q == S_FIN,
		!ram_we, "heap store written outside a sift")
	`BMHPQ_ASSERT_SAME(a_write_in_heap, clk, arst_n, ram_we && count_q != '0,
		CW'(ram_waddr) < count_q, "heap store written beyond the last entry")
	`BMHPQ_ASSERT_NEXT(a_insert_grows, clk, arst_n,
		accept && in_req.mode == bmhpq_pkg::MODE_INSERT && count_q != CW'(CAPACITY),
		count_q == $past(count_q) + 1'b1, "accepted insert did not add an entry")

endmodule

// ===== rtl/core/binary_min_heap_priority_queue_top.sv =====
// binary min-heap priority queue: request and result channels, heap ram, sequencer
// and result output register; depends on bmhpq_pkg, bmhpq_if, bmhpq_ram, bmhpq_ctrl
//
// usage
// - req channel: one beat per operation; mode selects insert (new_priority, new_tag)
//   or remove of the entry with the smallest priority
// - rsp channel: exactly one beat per request, in request order, carrying status,
//   the removed entry (zero unless a remove succeeded) and the occupancy afterwards
// - one operation at a time: req.ready is high only while the sequencer is idle, so
//   the next request beat comes at the earliest on the edge of the previous result beat
// - insert: the entry sifts up, each level a read of the parent (S_UP_RD) and a
//   compare (S_UP_CMP); remove: the root and the last entry are captured (S_RM_CAP),
//   then each level reads both children (S_DN_RD), selects the smaller (S_DN_SEL)
//   and compares it (S_DN_CMP); a refused insert or remove goes straight to the result
// - each level of the sift walk needs a registered heap ram read and a pass
//   through the single key comparator (two for sift-down)
// - reset empties the heap at once; the ram is never cleared, as only slots
//   below the entry count are ever read
// - a stalled receiver holds the result in the output register; the sequencer
//   parks on its finished result and the next request waits until it moves on
module binary_min_heap_priority_queue_top #(
	parameter int unsigned CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bmhpq_req_if.sink    req,
	bmhpq_rsp_if.source  rsp
);

	localparam int unsigned AW = $clog2(CAPACITY);

	// request beat gathered into one struct
	bmhpq_pkg::req_t               req_beat;
	// sequencer result handoff
	bmhpq_pkg::res_t               res;
	logic                          res_valid;
	logic                          res_ready;
	// heap ram ports
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [bmhpq_pkg::ENTRY_W-1:0] ram_wdata;
	logic [AW-1:0]                 ram_raddr_a;
	logic [AW-1:0]                 ram_raddr_b;
	logic [bmhpq_pkg::ENTRY_W-1:0] ram_rdata_a;
	logic [bmhpq_pkg::ENTRY_W-1:0] ram_rdata_b;
	// output register
	logic                          rsp_valid_q;
	bmhpq_pkg::res_t               rsp_q;

	assign req_beat.mode         = req.mode;
	assign req_beat.new_priority = req.new_priority;
	assign req_beat.new_tag      = req.new_tag;

	// heap storage, one entry per slot, priority in the upper half
	bmhpq_ram #(
		.WIDTH(bmhpq_pkg::ENTRY_W),
		.DEPTH(CAPACITY)
	) u_heap_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	// sift sequencer with the shared comparator
	bmhpq_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_ready    (req.ready),
		.in_req      (req_beat),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr_a (ram_raddr_a),
		.ram_raddr_b (ram_raddr_b),
		.ram_rdata_a (ram_rdata_a),
		.ram_rdata_b (ram_rdata_b)
	);

	// output register: loads when empty or when its beat is taken this cycle
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_q.status;
	assign rsp.out_priority = rsp_q.out_priority;
	assign rsp.out_tag      = rsp_q.out_tag;
	assign rsp.occupancy    = rsp_q.occupancy;

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for binary_min_heap_priority_queue_top: directed rows, then random beats
// checked against a behavioural heap predictor kept alongside the block
// depends on bmhpq_pkg, bmhpq_if and the rtl under rtl/core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned HEAP_DEPTH     = bmhpq_pkg::CAPACITY_DEF;
	localparam int          LONG_HOLD      = 400;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          END_SETTLE     = 40;
	localparam int          MAX_REPORTS    = 10;

	// one directed row: the request, and where obvious the result typed in by hand
	typedef struct packed {
		bmhpq_pkg::req_t op;
		logic            typed;
		bmhpq_pkg::res_t want;
	} step_row_t;

	logic clk;
	logic arst_n;

	bmhpq_req_if req_ch ();
	bmhpq_rsp_if rsp_ch ();

	binary_min_heap_priority_queue_top #(
		.CAPACITY(HEAP_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// predictor state: our own copy of the heap and its entry count
	bmhpq_pkg::entry_t heap_mem [HEAP_DEPTH];
	int unsigned       heap_count = 0;

	// results still owed by the block, oldest first
	bmhpq_pkg::res_t   pending_results [$];
	step_row_t         directed_rows [$];

	// driver side-band: typed-in result travelling with the request beat
	logic              drv_typed;
	bmhpq_pkg::res_t   drv_expect;

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          stall_token   = 0;
	int          stall_seen    = 0;
	int          fail_count    = 0;
	int          quiet_cycles  = 0;

	// clock: 8 ns period
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// apply one request to the predictor heap and return the result it owes
	function automatic bmhpq_pkg::res_t apply_heap_op(input bmhpq_pkg::req_t op);
		bmhpq_pkg::res_t   r;
		bmhpq_pkg::entry_t tmp;
		int unsigned pos;
		int unsigned parent;
		int unsigned left;
		int unsigned pick;
		r        = '0;
		r.status = bmhpq_pkg::ST_DONE;
		if (op.mode == bmhpq_pkg::MODE_INSERT) begin
			if (heap_count >= HEAP_DEPTH) begin
				r.status = bmhpq_pkg::ST_FULL;
			end else begin
				// new entry at the end, then sift up while the parent is strictly greater
				pos           = heap_count;
				heap_mem[pos] = bmhpq_pkg::entry_t'({op.new_priority, op.new_tag});
				while (pos != 0) begin
					parent = (pos - 1) / 2;
					if (heap_mem[parent].prio <= heap_mem[pos].prio)
						break;
					tmp              = heap_mem[parent];
					heap_mem[parent] = heap_mem[pos];
					heap_mem[pos]    = tmp;
					pos              = parent;
				end
				heap_count++;
			end
		end else if (heap_count == 0) begin
			r.status = bmhpq_pkg::ST_EMPTY;
		end else begin
			r.out_priority = heap_mem[0].prio;
			r.out_tag      = heap_mem[0].tag;
			heap_count--;
			heap_mem[0]    = heap_mem[heap_count];
			// sift down: smaller child, left one on a tie, swap only if strictly greater
			pos  = 0;
			left = 1;
			while (left < heap_count) begin
				pick = left;
				if (left + 1 < heap_count && heap_mem[left + 1].prio < heap_mem[left].prio)
					pick = left + 1;
				if (heap_mem[pos].prio <= heap_mem[pick].prio)
					break;
				tmp            = heap_mem[pick];
				heap_mem[pick] = heap_mem[pos];
				heap_mem[pos]  = tmp;
				pos            = pick;
				left           = 2 * pos + 1;
			end
		end
		r.occupancy = bmhpq_pkg::OCC_W'(heap_count);
		return r;
	endfunction

	// random key: small values for ties, the two extremes, or anything
	function automatic logic [bmhpq_pkg::KEY_W-1:0] rand_key();
		case ($urandom_range(3))
			0: begin
				return bmhpq_pkg::KEY_W'($urandom_range(7));
			end
			1: begin
				return $urandom_range(1) ? {bmhpq_pkg::KEY_W{1'b1}} : {bmhpq_pkg::KEY_W{1'b0}};
			end
			default: begin
				return bmhpq_pkg::KEY_W'($urandom);
			end
		endcase
	endfunction

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%s", what);
	endtask

	task automatic add_row(input logic mode, input logic [bmhpq_pkg::KEY_W-1:0] key,
			input logic [bmhpq_pkg::TAG_W-1:0] tag, input logic typed,
			input logic [bmhpq_pkg::STATUS_W-1:0] st,
			input logic [bmhpq_pkg::KEY_W-1:0] out_key,
			input logic [bmhpq_pkg::TAG_W-1:0] out_tag,
			input logic [bmhpq_pkg::OCC_W-1:0] occ);
		directed_rows.push_back(step_row_t'({mode, key, tag, typed, st, out_key, out_tag, occ}));
	endtask

	// offer one request beat, with random idle cycles in front, and wait until it is taken
	task automatic send_op(input bmhpq_pkg::req_t op, input logic typed,
			input bmhpq_pkg::res_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.mode         <= op.mode;
		req_ch.new_priority <= op.new_priority;
		req_ch.new_tag      <= op.new_tag;
		drv_typed           <= typed;
		drv_expect          <= want;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_item(input logic mode, input logic [bmhpq_pkg::KEY_W-1:0] key,
			input logic [bmhpq_pkg::TAG_W-1:0] tag);
		send_op(bmhpq_pkg::req_t'({mode, key, tag}), 1'b0, '0);
	endtask

	// sender pause: stop offering and wait until every owed result has arrived
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// one idling phase: a fill to the brim, random sequences, then a full drain
	task automatic run_phase(input int sender_idle, input int receiver_idle,
			input int quota, input bit long_hold);
		int sent;
		int len;
		int ins_pct;
		send_idle_pct = sender_idle;
		recv_idle_pct <= receiver_idle;
		sent = HEAP_DEPTH + 2;
		// fill past capacity so the last inserts are refused
		repeat (HEAP_DEPTH + 2)
			send_item(bmhpq_pkg::MODE_INSERT, rand_key(), bmhpq_pkg::TAG_W'($urandom));
		wait_drained();
		// receiver holds off for a long stretch while the sender keeps offering
		if (long_hold)
			stall_token <= stall_token + 1;
		while (sent < quota) begin
			case ($urandom_range(8))
				0: begin
					// fill burst
					len = HEAP_DEPTH + $urandom_range(1, 4);
					repeat (len)
						send_item(bmhpq_pkg::MODE_INSERT, rand_key(),
							bmhpq_pkg::TAG_W'($urandom));
				end
				1: begin
					// drain burst, running past empty
					len = HEAP_DEPTH + $urandom_range(1, 3);
					repeat (len)
						send_item(bmhpq_pkg::MODE_REMOVE, rand_key(),
							bmhpq_pkg::TAG_W'($urandom));
				end
				7: begin
					// crowded keys to exercise the tie rules in both sifts
					len = $urandom_range(10, 30);
					repeat (len)
						send_item(($urandom_range(99) < 60) ? bmhpq_pkg::MODE_INSERT :
							bmhpq_pkg::MODE_REMOVE, bmhpq_pkg::KEY_W'($urandom_range(3)),
							bmhpq_pkg::TAG_W'($urandom));
				end
				8: begin
					// noise: anything goes
					len = $urandom_range(5, 20);
					repeat (len)
						send_item(1'($urandom), bmhpq_pkg::KEY_W'($urandom),
							bmhpq_pkg::TAG_W'($urandom));
				end
				default: begin
					// mixed run with a random insert bias
					len     = $urandom_range(20, 60);
					ins_pct = $urandom_range(30, 70);
					repeat (len)
						send_item(($urandom_range(99) < ins_pct) ? bmhpq_pkg::MODE_INSERT :
							bmhpq_pkg::MODE_REMOVE, rand_key(), bmhpq_pkg::TAG_W'($urandom));
				end
			endcase
			sent += len;
		end
		repeat (HEAP_DEPTH + 3)
			send_item(bmhpq_pkg::MODE_REMOVE, rand_key(), bmhpq_pkg::TAG_W'($urandom));
		wait_drained();
	endtask

	// receiver: random stalls, plus a long hold-off counted here when asked for
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_token != stall_seen) begin
				stall_seen = stall_token;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1)
					@(posedge clk);
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// beat monitor: predicts on every request beat, checks every result beat,
	// and runs the watchdog on stretches with no beat at all
	always @(posedge clk) begin : beat_monitor
		bmhpq_pkg::res_t seen;
		bmhpq_pkg::res_t want;
		bmhpq_pkg::req_t op;
		bmhpq_pkg::res_t predicted;
		logic any_beat;
		if (arst_n) begin
			any_beat = 1'b0;
			if (rsp_ch.valid && rsp_ch.ready) begin
				any_beat = 1'b1;
				seen     = bmhpq_pkg::res_t'({rsp_ch.status, rsp_ch.out_priority,
					rsp_ch.out_tag, rsp_ch.occupancy});
				if (pending_results.size() == 0) begin
					note_failure($sformatf("unexpected result beat: status %0d prio %h tag %h occ %0d",
						seen.status, seen.out_priority, seen.out_tag, seen.occupancy));
				end else begin
					want = pending_results.pop_front();
					if (want.status != seen.status || want.out_priority != seen.out_priority ||
							want.out_tag != seen.out_tag || want.occupancy != seen.occupancy)
						note_failure($sformatf({"result mismatch: expected status %0d prio %h ",
							"tag %h occ %0d, got status %0d prio %h tag %h occ %0d"},
							want.status, want.out_priority, want.out_tag, want.occupancy,
							seen.status, seen.out_priority, seen.out_tag, seen.occupancy));
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				any_beat  = 1'b1;
				op        = bmhpq_pkg::req_t'({req_ch.mode, req_ch.new_priority,
					req_ch.new_tag});
				predicted = apply_heap_op(op);
				// typed-in rows are checked against the hand-written value
				pending_results.push_back(drv_typed ? drv_expect : predicted);
			end
			if (any_beat)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("binary_min_heap_priority_queue_top test failed");
				$finish;
			end
		end
	end

	// main sequence: reset, directed rows, three idling phases, then a settle before the verdict
	initial begin
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.mode         = bmhpq_pkg::MODE_INSERT;
		req_ch.new_priority = '0;
		req_ch.new_tag      = '0;
		drv_typed           = 1'b0;
		drv_expect          = '0;

		// remove on an empty heap, single entry at the top extremes
		add_row(bmhpq_pkg::MODE_REMOVE, 16'h0000, 16'h0000, 1'b1, bmhpq_pkg::ST_EMPTY,
			16'h0000, 16'h0000, 8'd0);
		add_row(bmhpq_pkg::MODE_INSERT, 16'hffff, 16'hffff, 1'b1, bmhpq_pkg::ST_DONE,
			16'h0000, 16'h0000, 8'd1);
		add_row(bmhpq_pkg::MODE_REMOVE, 16'h0000, 16'h0000, 1'b1, bmhpq_pkg::ST_DONE,
			16'hffff, 16'hffff, 8'd0);
		add_row(bmhpq_pkg::MODE_REMOVE, 16'hffff, 16'hffff, 1'b1, bmhpq_pkg::ST_EMPTY,
			16'h0000, 16'h0000, 8'd0);
		// inserts: bottom extremes, ties with the root and on the way up
		add_row(bmhpq_pkg::MODE_INSERT, 16'h0000, 16'h0000, 1'b1, bmhpq_pkg::ST_DONE,
			16'h0000, 16'h0000, 8'd1);
		add_row(bmhpq_pkg::MODE_INSERT, 16'hffff, 16'h0000, 1'b1, bmhpq_pkg::ST_DONE,
			16'h0000, 16'h0000, 8'd2);
		add_row(bmhpq_pkg::MODE_INSERT, 16'h0000, 16'hffff, 1'b1, bmhpq_pkg::ST_DONE,
			16'h0000, 16'h0000, 8'd3);
		add_row(bmhpq_pkg::MODE_INSERT, 16'h8000, 16'h1234, 1'b1, bmhpq_pkg::ST_DONE,
			16'h0000, 16'h0000, 8'd4);
		add_row(bmhpq_pkg::MODE_INSERT, 16'h0001, 16'h00aa, 1'b1, bmhpq_pkg::ST_DONE,
			16'h0000, 16'h0000, 8'd5);
		add_row(bmhpq_pkg::MODE_INSERT, 16'h0000, 16'h5555, 1'b1, bmhpq_pkg::ST_DONE,
			16'h0000, 16'h0000, 8'd6);
		add_row(bmhpq_pkg::MODE_INSERT, 16'h7fff, 16'haaaa, 1'b1, bmhpq_pkg::ST_DONE,
			16'h0000, 16'h0000, 8'd7);
		add_row(bmhpq_pkg::MODE_INSERT, 16'h0001, 16'h0f0f, 1'b1, bmhpq_pkg::ST_DONE,
			16'h0000, 16'h0000, 8'd8);
		// removal order among equal keys comes from the predictor
		repeat (8)
			add_row(bmhpq_pkg::MODE_REMOVE, 16'h0000, 16'h0000, 1'b0, bmhpq_pkg::ST_DONE,
				16'h0000, 16'h0000, 8'd0);
		add_row(bmhpq_pkg::MODE_REMOVE, 16'h0000, 16'h0000, 1'b1, bmhpq_pkg::ST_EMPTY,
			16'h0000, 16'h0000, 8'd0);

		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 20;
		recv_idle_pct <= 56;
		foreach (directed_rows[i])
			send_op(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want);
		wait_drained();

		run_phase(20, 56, 305, 1'b1);
		run_phase(56, 20, 305, 1'b0);
		run_phase(0, 0, 295, 1'b0);

		// let any stray late beat show itself before the verdict
		repeat (END_SETTLE)
			@(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("binary_min_heap_priority_queue_top test passed");
		else
			$display("binary_min_heap_priority_queue_top test failed");
		$finish;
	end

endmodule
